@@ rtl/ccl_pkg.sv @@
// Shared types, register indexes and LFSR round functions for the keystream XOR block.
package ccl_pkg;

   localparam int unsigned LFSR_W    = 80;
   localparam int unsigned KEY_BYTES = 30;
   localparam int unsigned KEY_W     = KEY_BYTES * 8;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 64;
   localparam int unsigned KW3_W     = 48;
   localparam int unsigned ROUNDS    = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] KEY_WORD_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] KEY_WORD_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] KEY_WORD_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] KEY_WORD_3 = CSR_IDX_W'(3);

   typedef logic [LFSR_W-1:0] lfsr_type;
   typedef logic [KEY_W-1:0]  key_type;

   typedef struct packed {
      lfsr_type a;
      lfsr_type b;
      lfsr_type c;
   } lfsr_state_type;

   // Control from the pipeline to the keystream generator
   typedef struct packed {
      logic advance;  // a transaction moves into the result register
      logic reload;   // that transaction starts a new message
   } ccl_ctl_type;

   // One step: OR the feedback into a tap position (bit 77 for A and B, bit 79 for C), then shift right
   function automatic lfsr_type step_a(lfsr_type x);
      lfsr_type t;
      t = x;
      t[77] = t[77] | (x[75] ^ x[6] ^ x[3] ^ x[1]);
      return {1'b0, t[LFSR_W-1:1]};
   endfunction

   function automatic lfsr_type step_b(lfsr_type x);
      lfsr_type t;
      t = x;
      t[77] = t[77] | (x[76] ^ x[6] ^ x[5] ^ x[2]);
      return {1'b0, t[LFSR_W-1:1]};
   endfunction

   function automatic lfsr_type step_c(lfsr_type x);
      lfsr_type t;
      t = x;
      t[79] = t[79] | (x[78] ^ x[4] ^ x[3] ^ x[2]);
      return {1'b0, t[LFSR_W-1:1]};
   endfunction

   // One clock-controlled round; A bits 2 and 77 gate the extra B and C steps
   function automatic lfsr_state_type round(lfsr_state_type s);
      lfsr_state_type r;
      lfsr_type b1;
      lfsr_type c1;
      b1  = s.a[2]  ? s.b : step_b(s.b);
      c1  = s.a[77] ? s.c : step_c(s.c);
      r.a = step_a(s.a);
      r.b = step_b(b1);
      r.c = step_c(c1);
      return r;
   endfunction

   // Ten key bytes from 'first', first byte most significant, top bit cleared
   function automatic lfsr_type load_reg(key_type key, int unsigned first);
      lfsr_type r;
      for (int unsigned j = 0; j < 10; j++) begin
         r[8*(9-j) +: 8] = key[8*(first+j) +: 8];
      end
      r[LFSR_W-1] = 1'b0;
      return r;
   endfunction

endpackage

@@ rtl/ccl_csr.sv @@
// Key register file written through the configuration port.
module ccl_csr
   import ccl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output key_type              key
);

   logic [CSR_DAT_W-1:0] kw0_ff, kw0_in;
   logic [CSR_DAT_W-1:0] kw1_ff, kw1_in;
   logic [CSR_DAT_W-1:0] kw2_ff, kw2_in;
   logic [KW3_W-1:0]     kw3_ff, kw3_in;

   assign csr_ready = 1'b1;

   // Decode the write; indexes past the last key word are dropped
   always_comb begin
      kw0_in = kw0_ff;
      kw1_in = kw1_ff;
      kw2_in = kw2_ff;
      kw3_in = kw3_ff;
      if (csr_valid) begin
         unique case (csr_index)
            KEY_WORD_0: kw0_in = csr_data;
            KEY_WORD_1: kw1_in = csr_data;
            KEY_WORD_2: kw2_in = csr_data;
            KEY_WORD_3: kw3_in = csr_data[KW3_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw0_ff <= '0;
         kw1_ff <= '0;
         kw2_ff <= '0;
         kw3_ff <= '0;
      end else begin
         kw0_ff <= kw0_in;
         kw1_ff <= kw1_in;
         kw2_ff <= kw2_in;
         kw3_ff <= kw3_in;
      end
   end

   // Byte k of the key sits at bits 8k+7..8k
   assign key = {kw3_ff, kw2_ff, kw1_ff, kw0_ff};

endmodule

@@ rtl/ccl_keygen.sv @@
// LFSR state registers and eight unrolled rounds producing one keystream byte.
module ccl_keygen
   import ccl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ccl_ctl_type ctl,
   input  key_type     key,
   output logic [7:0]  ks_byte
);

   lfsr_state_type state_ff, state_in;
   lfsr_state_type start;
   lfsr_state_type chain [ROUNDS+1];

   // Reload from the key at the start of a message
   always_comb begin
      start.a = ctl.reload ? load_reg(key, 0)  : state_ff.a;
      start.b = ctl.reload ? load_reg(key, 10) : state_ff.b;
      start.c = ctl.reload ? load_reg(key, 20) : state_ff.c;
   end

   assign chain[0] = start;

   // Round i yields keystream bit 7-i, MSB first
   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      assign ks_byte[ROUNDS-1-i] = chain[i].b[0] ^ chain[i].c[0];
      assign chain[i+1]          = round(chain[i]);
   end

   assign state_in = ctl.advance ? chain[ROUNDS] : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/clock_controlled_lfsr_stream_xor.sv @@
// A transaction accepted into the input register loads the result register once the result register is free.
// Throughput: one byte per cycle while the result is not stalled; the eight rounds run between the LFSR state
// register and the result register, so back-to-back bytes chain through the state.
// Reset clears the pipeline valids, the three LFSRs and all key registers to zero;
// until a first-of-message byte arrives the keystream is zero.
// Input and result stages are separate, so a byte is taken while a result waits if the input stage is empty.
module clock_controlled_lfsr_stream_xor
   import ccl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_in,
   input  logic                 req_first_of_message,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_data_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_data_ff, s1_data_in;
   logic        s1_first_ff, s1_first_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        out_ready;
   logic        req_accept;
   logic [7:0]  ks_byte;
   key_type     key;
   ccl_ctl_type ctl;

   ccl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key       (key)
   );

   ccl_keygen u_keygen (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .key     (key),
      .ks_byte (ks_byte)
   );

   // Handshake: result register frees when empty or being taken
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign ctl.advance = s1_valid_ff && out_ready;
   assign ctl.reload  = s1_first_ff;
   assign req_stall   = s1_valid_ff && !out_ready;
   assign req_accept  = req_valid && !req_stall;

   // Input stage
   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !ctl.advance);
      s1_data_in  = req_accept ? req_data_in : s1_data_ff;
      s1_first_in = req_accept ? req_first_of_message : s1_first_ff;
   end

   // Result stage
   always_comb begin
      rsp_valid_in = ctl.advance || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = ctl.advance ? (s1_data_ff ^ ks_byte) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_first_ff <= s1_first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

   // No result comes out of reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A held input transaction is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !ctl.advance) |=> s1_valid_ff)
      else $error("input stage lost a transaction");

   // Stall only when both stages are full and the result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule
